// ----- hw/rtl/bsc_pkg.sv -----
// constants, register indexes and helper functions for the b-spline calibrator
// no dependencies
package bsc_pkg;

  localparam int unsigned MaxDegree = 3;
  localparam int unsigned MeshDim   = 16;

  typedef enum logic [2:0] {
    CfgScaleX  = 3'd0,
    CfgOffsetX = 3'd1,
    CfgScaleY  = 3'd2,
    CfgOffsetY = 3'd3,
    CfgDegX    = 3'd4,
    CfgDegY    = 3'd5,
    CfgWidth   = 3'd6,
    CfgHeight  = 3'd7
  } cfg_idx_e;

  localparam logic FuncLoad = 1'b0;
  localparam logic FuncCal  = 1'b1;

  localparam logic [25:0] AlphaLimit = 26'd16777216;

  // reciprocal of the sub-degree, scaled by 2^28, exact for 26-bit dividends
  function automatic logic [28:0] recip(input logic [1:0] sub);
    logic [28:0] r;
    unique case (sub)
      2'd1:    r = 29'h10000000;
      2'd2:    r = 29'h08000000;
      2'd3:    r = 29'h05555556;
      default: r = 29'h0;
    endcase
    return r;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sh000000007fffffff) begin
      r = 32'sh7fffffff;
    end else if (v < -64'sh0000000080000000) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

// ----- hw/rtl/bspline_surface_calibrate.sv -----
// top level of the b-spline touch calibrator: mesh memory, sequencer, shared multiplier
// depends on bsc_pkg
//
//  channel | direction | handshake            | payload
//  in      | input     | in_valid_i/in_stall_o| func, raw_x, raw_y, mesh_col, mesh_row, point
//  out     | output    | out_valid_o/out_stall_i | screen_x, screen_y
//  cfg     | input     | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
// a load request is written to the mesh when it is taken, with no stall; a calibrate
// request scales the raw sample, finds the knot intervals, then reads and blends each
// row of points and blends the row results, using the one shared multiplier for
// every scale, weight and blend product; in_stall_o is high until the result is posted
// the result waits in an output register, so a new request is taken while it is stalled
// reset clears the registers to their defaults; the mesh memory and its read register rd_q are not cleared
module bspline_surface_calibrate (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        func_i,
  input  logic [11:0] raw_x_i,
  input  logic [11:0] raw_y_i,
  input  logic [3:0]  mesh_col_i,
  input  logic [3:0]  mesh_row_i,
  input  logic signed [31:0] point_x_i,
  input  logic signed [31:0] point_y_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic signed [31:0] screen_x_o,
  output logic signed [31:0] screen_y_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  typedef enum logic [3:0] {
    StIdle, StMx, StMxw, StMyw, StIv, StRd, StRdw, StLvl,
    StWt, StWtw, StBx, StBxw, StByw, StOut
  } state_e;

  state_e state_q;

  logic signed [31:0] scale_x_q, offset_x_q, scale_y_q, offset_y_q;
  logic [1:0] deg_x_q, deg_y_q;
  logic [4:0] width_q, height_q;

  logic [11:0] raw_x_q, raw_y_q;
  logic signed [31:0] mx_q, my_q;
  logic [3:0] ivx_q, ivy_q;
  logic [1:0] r_q, c_q, sub_q, j_q;
  logic phase_q;
  logic [63:0] q_q [4];
  logic [63:0] ys_q [4];
  logic [63:0] rd_q;
  logic signed [25:0] alpha_q;
  logic signed [31:0] nx_q;
  logic signed [60:0] prod_q;
  logic out_valid_q;
  logic signed [31:0] out_x_q, out_y_q;

  logic [63:0] mesh [256];

  logic in_acc;
  assign in_stall_o  = (state_q != StIdle);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign screen_x_o  = out_x_q;
  assign screen_y_o  = out_y_q;

  // mesh limits
  logic [4:0] w_lim, h_lim;
  always_comb begin
    w_lim = width_q;
    if (w_lim < 5'(deg_x_q) + 5'd1) w_lim = 5'(deg_x_q) + 5'd1;
    if (w_lim > 5'(bsc_pkg::MeshDim)) w_lim = 5'(bsc_pkg::MeshDim);
    h_lim = height_q;
    if (h_lim < 5'(deg_y_q) + 5'd1) h_lim = 5'(deg_y_q) + 5'd1;
    if (h_lim > 5'(bsc_pkg::MeshDim)) h_lim = 5'(bsc_pkg::MeshDim);
  end

  function automatic logic [3:0] interval(input logic signed [31:0] m,
                                          input logic [1:0] d, input logic [4:0] s);
    logic signed [15:0] k;
    logic [3:0] r;
    k = m[31:16];
    if (k < $signed({14'd0, d})) begin
      r = 4'(d);
    end else if (k > $signed({11'd0, s - 5'd1})) begin
      r = 4'(s - 5'd1);
    end else begin
      r = k[3:0];
    end
    return r;
  endfunction

  // weight operand
  logic signed [31:0] m_cur;
  logic [3:0] iv_cur, base;
  logic signed [33:0] dm;
  logic [33:0] mag;
  logic neg, big;
  always_comb begin
    m_cur  = phase_q ? my_q : mx_q;
    iv_cur = phase_q ? ivy_q : ivx_q;
    base   = iv_cur - 4'(sub_q) + 4'd1 + 4'(j_q);
    dm     = {{2{m_cur[31]}}, m_cur} - $signed({14'd0, base, 16'd0});
    neg    = dm[33];
    mag    = neg ? 34'(-dm) : 34'(dm);
    big    = |mag[33:26];
  end

  // blend operands
  logic signed [31:0] p0x, p0y, p1x, p1y;
  assign p0x = q_q[0][63:32];
  assign p0y = q_q[0][31:0];
  assign p1x = q_q[1][63:32];
  assign p1y = q_q[1][31:0];

  // shared multiplier
  logic signed [33:0] mul_a;
  logic signed [26:0] mul_b;
  logic signed [60:0] prod_d;
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      StMx: begin
        mul_a = 34'(scale_x_q);
        mul_b = $signed({15'd0, raw_x_q});
      end
      StMxw: begin
        mul_a = 34'(scale_y_q);
        mul_b = $signed({15'd0, raw_y_q});
      end
      StWt: begin
        mul_a = $signed({5'd0, bsc_pkg::recip(sub_q)});
        mul_b = $signed({1'b0, mag[25:0]});
      end
      StBx: begin
        mul_a = 34'(p1x) - 34'(p0x);
        mul_b = 27'(alpha_q);
      end
      StBxw: begin
        mul_a = 34'(p1y) - 34'(p0y);
        mul_b = 27'(alpha_q);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    prod_d = 61'(mul_a) * 61'(mul_b);
  end

  logic signed [63:0] prod64, mesh_sum_x, mesh_sum_y, blend_x, blend_y;
  logic [26:0] qdiv;
  logic [25:0] amag;
  always_comb begin
    prod64     = {{3{prod_q[60]}}, prod_q};
    mesh_sum_x = (prod64 >>> 8) + 64'(offset_x_q);
    mesh_sum_y = (prod64 >>> 8) + 64'(offset_y_q);
    blend_x    = (prod64 >>> 16) + 64'(p0x);
    blend_y    = (prod64 >>> 16) + 64'(p0y);
    qdiv       = prod_q[54:28];
    if (big || qdiv > 27'(bsc_pkg::AlphaLimit)) begin
      amag = bsc_pkg::AlphaLimit;
    end else begin
      amag = qdiv[25:0];
    end
  end

  logic [3:0] rd_row, rd_col;
  assign rd_row = ivy_q - 4'(deg_y_q) + 4'(r_q);
  assign rd_col = ivx_q - 4'(deg_x_q) + 4'(c_q);

  // mesh memory
  always_ff @(posedge clk_i) begin
    if (in_acc && func_i == bsc_pkg::FuncLoad) begin
      mesh[{mesh_row_i, mesh_col_i}] <= {point_x_i, point_y_i};
    end
    if (state_q == StRd) begin
      rd_q <= mesh[{rd_row, rd_col}];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      scale_x_q   <= 32'sd16777216;
      offset_x_q  <= '0;
      scale_y_q   <= 32'sd16777216;
      offset_y_q  <= '0;
      deg_x_q     <= 2'd3;
      deg_y_q     <= 2'd3;
      width_q     <= 5'd4;
      height_q    <= 5'd4;
      raw_x_q     <= '0;
      raw_y_q     <= '0;
      mx_q        <= '0;
      my_q        <= '0;
      ivx_q       <= '0;
      ivy_q       <= '0;
      r_q         <= '0;
      c_q         <= '0;
      sub_q       <= '0;
      j_q         <= '0;
      phase_q     <= 1'b0;
      q_q         <= '{default: '0};
      ys_q        <= '{default: '0};
      alpha_q     <= '0;
      nx_q        <= '0;
      prod_q      <= '0;
      out_valid_q <= 1'b0;
      out_x_q     <= '0;
      out_y_q     <= '0;
    end else begin
      prod_q <= prod_d;
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_valid_i) begin
        unique case (bsc_pkg::cfg_idx_e'(cfg_index_i))
          bsc_pkg::CfgScaleX:  scale_x_q  <= cfg_data_i;
          bsc_pkg::CfgOffsetX: offset_x_q <= cfg_data_i;
          bsc_pkg::CfgScaleY:  scale_y_q  <= cfg_data_i;
          bsc_pkg::CfgOffsetY: offset_y_q <= cfg_data_i;
          bsc_pkg::CfgDegX:    deg_x_q    <= cfg_data_i[1:0];
          bsc_pkg::CfgDegY:    deg_y_q    <= cfg_data_i[1:0];
          bsc_pkg::CfgWidth:   width_q    <= cfg_data_i[4:0];
          bsc_pkg::CfgHeight:  height_q   <= cfg_data_i[4:0];
          default: ;
        endcase
      end
      unique case (state_q)
        StIdle: begin
          if (in_acc && func_i == bsc_pkg::FuncCal) begin
            raw_x_q <= raw_x_i;
            raw_y_q <= raw_y_i;
            state_q <= StMx;
          end
        end
        StMx: state_q <= StMxw;
        StMxw: begin
          mx_q    <= bsc_pkg::sat32(mesh_sum_x);
          state_q <= StMyw;
        end
        StMyw: begin
          my_q    <= bsc_pkg::sat32(mesh_sum_y);
          state_q <= StIv;
        end
        StIv: begin
          ivx_q   <= interval(mx_q, deg_x_q, w_lim);
          ivy_q   <= interval(my_q, deg_y_q, h_lim);
          r_q     <= '0;
          c_q     <= '0;
          phase_q <= 1'b0;
          state_q <= StRd;
        end
        StRd: state_q <= StRdw;
        StRdw: begin
          q_q[c_q] <= rd_q;
          if (c_q == deg_x_q) begin
            sub_q   <= deg_x_q;
            j_q     <= '0;
            state_q <= StLvl;
          end else begin
            c_q     <= c_q + 2'd1;
            state_q <= StRd;
          end
        end
        StLvl: begin
          if (sub_q == 2'd0) begin
            if (phase_q) begin
              state_q <= StOut;
            end else begin
              ys_q[r_q] <= q_q[0];
              if (r_q == deg_y_q) begin
                q_q     <= '{ys_q[0], ys_q[1], ys_q[2], ys_q[3]};
                q_q[r_q] <= q_q[0];
                phase_q <= 1'b1;
                sub_q   <= deg_y_q;
                j_q     <= '0;
              end else begin
                r_q     <= r_q + 2'd1;
                c_q     <= '0;
                state_q <= StRd;
              end
            end
          end else if (j_q == sub_q) begin
            q_q[0]  <= q_q[1];
            q_q[1]  <= q_q[2];
            q_q[2]  <= q_q[3];
            sub_q   <= sub_q - 2'd1;
            j_q     <= '0;
          end else begin
            state_q <= StWt;
          end
        end
        StWt: state_q <= StWtw;
        StWtw: begin
          alpha_q <= neg ? -$signed(amag) : $signed(amag);
          state_q <= StBx;
        end
        StBx: state_q <= StBxw;
        StBxw: begin
          nx_q    <= bsc_pkg::sat32(blend_x);
          state_q <= StByw;
        end
        StByw: begin
          q_q[0]     <= q_q[1];
          q_q[1]     <= q_q[2];
          q_q[2]     <= q_q[3];
          q_q[sub_q] <= {nx_q, bsc_pkg::sat32(blend_y)};
          j_q        <= j_q + 2'd1;
          state_q    <= StLvl;
        end
        StOut: begin
          if (!out_valid_q || !out_stall_i) begin
            out_x_q     <= q_q[0][63:32];
            out_y_q     <= q_q[0][31:0];
            out_valid_q <= 1'b1;
            state_q     <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  a_step_in_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StLvl) |-> (j_q <= sub_q))
    else $error("de boor slot beyond level");

  a_read_in_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StRd) |-> (c_q <= deg_x_q && r_q <= deg_y_q))
    else $error("mesh read outside the point window");

  a_interval_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StRd) |-> (ivx_q >= 4'(deg_x_q) && ivy_q >= 4'(deg_y_q)))
    else $error("interval below degree");

  a_result_posted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StOut && !(out_valid_q && out_stall_i)) |=> (out_valid_q && state_q == StIdle))
    else $error("result not posted");

endmodule

// ----- tb/bspline_surface_calibrate_test.sv -----
// testbench for the b-spline touch calibrator: directed and random requests, with an
// in-bench spline predictor checking every calibrated point; depends on bsc_pkg and the rtl
`timescale 1ns / 1ps
module bspline_surface_calibrate_test;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic func_i = bsc_pkg::FuncLoad;
  logic [11:0] raw_x_i = '0;
  logic [11:0] raw_y_i = '0;
  logic [3:0] mesh_col_i = '0;
  logic [3:0] mesh_row_i = '0;
  logic signed [31:0] point_x_i = '0;
  logic signed [31:0] point_y_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic signed [31:0] screen_x_o;
  logic signed [31:0] screen_y_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [2:0] cfg_index_i = '0;
  logic [31:0] cfg_data_i = '0;

  typedef struct packed {
    logic signed [31:0] sx;
    logic signed [31:0] sy;
  } screen_pt_t;

  screen_pt_t expected_points[$];
  logic [31:0] cal_regs [8];
  logic signed [31:0] grid_x [256];
  logic signed [31:0] grid_y [256];
  int errors = 0;
  bit steady = 1'b0;

  bspline_surface_calibrate dut (.*);

  always #10 clk_i = ~clk_i;

  initial begin
    #60000000;
    $display("simulation failed");
    $finish;
  end

  always @(negedge clk_i) begin
    out_stall_i <= steady ? 1'b0 : ($urandom_range(99) < 37);
  end

  function automatic longint sat32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic void axis_limits(input logic [31:0] dreg, input logic [31:0] sreg,
                                      output int d, output int s);
    d = int'(dreg);
    s = int'(sreg);
    if (d > bsc_pkg::MaxDegree) d = bsc_pkg::MaxDegree;
    if (d > bsc_pkg::MeshDim - 1) d = bsc_pkg::MeshDim - 1;
    if (s < d + 1) s = d + 1;
    if (s > bsc_pkg::MeshDim) s = bsc_pkg::MeshDim;
  endfunction

  function automatic longint raw_to_mesh(input logic [11:0] raw, input logic [31:0] scale,
                                         input logic [31:0] offset);
    longint p;
    p = longint'(raw) * longint'($signed(scale));
    return sat32((p >>> 8) + longint'($signed(offset)));
  endfunction

  function automatic int knot_span(input longint m, input int d, input int s);
    longint k;
    k = m >>> 16;
    if (k < d) k = d;
    if (k > s - 1) k = s - 1;
    return int'(k);
  endfunction

  function automatic longint lerp_fixed(input longint a, input longint b, input longint alpha);
    return sat32(a + ((alpha * (b - a)) >>> 16));
  endfunction

  function automatic void reduce(inout longint px [4], inout longint py [4], input int d,
                                 input int span, input longint m);
    longint a;
    int sub;
    for (int k = 0; k < d; k++) begin
      sub = d - k;
      for (int j = 0; j < sub; j++) begin
        a = (m - longint'(span - sub + 1 + j) * 65536) / sub;
        if (a > 64'sd16777216) a = 64'sd16777216;
        if (a < -64'sd16777216) a = -64'sd16777216;
        px[j] = lerp_fixed(px[j], px[j + 1], a);
        py[j] = lerp_fixed(py[j], py[j + 1], a);
      end
    end
  endfunction

  function automatic screen_pt_t calibrate_point(input logic [11:0] rx, input logic [11:0] ry);
    int dx, dy, w, h, spx, spy, row;
    longint mx, my;
    longint px [4];
    longint py [4];
    longint qx [4];
    longint qy [4];
    screen_pt_t r;
    axis_limits(cal_regs[bsc_pkg::CfgDegX], cal_regs[bsc_pkg::CfgWidth], dx, w);
    axis_limits(cal_regs[bsc_pkg::CfgDegY], cal_regs[bsc_pkg::CfgHeight], dy, h);
    mx = raw_to_mesh(rx, cal_regs[bsc_pkg::CfgScaleX], cal_regs[bsc_pkg::CfgOffsetX]);
    my = raw_to_mesh(ry, cal_regs[bsc_pkg::CfgScaleY], cal_regs[bsc_pkg::CfgOffsetY]);
    spx = knot_span(mx, dx, w);
    spy = knot_span(my, dy, h);
    for (int i = 0; i < 4; i++) begin
      qx[i] = 0;
      qy[i] = 0;
    end
    for (int rr = 0; rr <= dy; rr++) begin
      row = spy - dy + rr;
      for (int c = 0; c < 4; c++) begin
        px[c] = 0;
        py[c] = 0;
      end
      for (int c = 0; c <= dx; c++) begin
        px[c] = grid_x[8'(row * bsc_pkg::MeshDim + spx - dx + c)];
        py[c] = grid_y[8'(row * bsc_pkg::MeshDim + spx - dx + c)];
      end
      reduce(px, py, dx, spx, mx);
      qx[rr] = px[0];
      qy[rr] = py[0];
    end
    reduce(qx, qy, dy, spy, my);
    r.sx = qx[0][31:0];
    r.sy = qy[0][31:0];
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $time);
    errors++;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_points.size() == 0) begin
        report_mismatch("unexpected result x", screen_x_o, '0);
      end else begin
        if (screen_x_o !== expected_points[0].sx)
          report_mismatch("screen_x", screen_x_o, expected_points[0].sx);
        if (screen_y_o !== expected_points[0].sy)
          report_mismatch("screen_y", screen_y_o, expected_points[0].sy);
        void'(expected_points.pop_front());
      end
    end
  end

  task automatic send_request(input logic f, input logic [11:0] rx, input logic [11:0] ry,
                              input logic [3:0] col, input logic [3:0] row,
                              input logic [31:0] ptx, input logic [31:0] pty);
    @(negedge clk_i);
    if (!steady && $urandom_range(99) < 37) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(4, 1)) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    func_i <= f;
    raw_x_i <= rx;
    raw_y_i <= ry;
    mesh_col_i <= col;
    mesh_row_i <= row;
    point_x_i <= ptx;
    point_y_i <= pty;
    do @(posedge clk_i); while (in_stall_o);
    if (f == bsc_pkg::FuncLoad) begin
      grid_x[{row, col}] = ptx;
      grid_y[{row, col}] = pty;
    end else begin
      expected_points = {expected_points, calibrate_point(rx, ry)};
    end
  endtask

  task automatic load_point(input int col, input int row, input logic [31:0] ptx,
                            input logic [31:0] pty);
    send_request(bsc_pkg::FuncLoad, 12'($urandom), 12'($urandom), 4'(col), 4'(row),
                 ptx, pty);
  endtask

  task automatic calibrate(input logic [11:0] rx, input logic [11:0] ry);
    send_request(bsc_pkg::FuncCal, rx, ry, 4'($urandom), 4'($urandom), $urandom, $urandom);
  endtask

  task automatic drain;
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (expected_points.size() != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
  endtask

  task automatic write_reg(input bsc_pkg::cfg_idx_e idx, input logic [31:0] value);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      bsc_pkg::CfgDegX, bsc_pkg::CfgDegY: cal_regs[idx] = value & 32'h3;
      bsc_pkg::CfgWidth, bsc_pkg::CfgHeight: cal_regs[idx] = value & 32'h1f;
      default: cal_regs[idx] = value;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic set_shape(input int dx, input int dy, input int w, input int h);
    write_reg(bsc_pkg::CfgDegX, dx);
    write_reg(bsc_pkg::CfgDegY, dy);
    write_reg(bsc_pkg::CfgWidth, w);
    write_reg(bsc_pkg::CfgHeight, h);
  endtask

  // scale so that the raw range spans roughly the mesh, with a little overhang
  task automatic fit_scales(input int w, input int h);
    write_reg(bsc_pkg::CfgScaleX, w * 4096 + $signed($urandom_range(800)) - 400);
    write_reg(bsc_pkg::CfgOffsetX, $signed($urandom_range(131072)) - 65536);
    write_reg(bsc_pkg::CfgScaleY, h * 4096 + $signed($urandom_range(800)) - 400);
    write_reg(bsc_pkg::CfgOffsetY, $signed($urandom_range(131072)) - 65536);
  endtask

  function automatic logic [31:0] mesh_value();
    if ($urandom_range(9) == 0) return $urandom;
    return $signed($urandom_range(32'h08000000)) - 32'sh04000000;
  endfunction

  task automatic test_fill_mesh;
    for (int r = 0; r < bsc_pkg::MeshDim; r++)
      for (int c = 0; c < bsc_pkg::MeshDim; c++)
        load_point(c, r, mesh_value(), mesh_value());
  endtask

  task automatic test_reset_defaults;
    calibrate(12'd0, 12'd0);
    calibrate(12'd4095, 12'd4095);
    calibrate(12'd2, 12'd3);
    drain();
  endtask

  task automatic test_directed;
    load_point(15, 15, 32'h7fffffff, 32'h80000000);
    load_point(0, 0, 32'h80000000, 32'h7fffffff);
    load_point(1, 0, 32'h7fffffff, 32'h80000000);
    drain();
    // degree zero and undersized mesh
    set_shape(0, 0, 0, 1);
    write_reg(bsc_pkg::CfgScaleX, 32'h01000000);
    write_reg(bsc_pkg::CfgOffsetX, 32'h0);
    write_reg(bsc_pkg::CfgScaleY, 32'h01000000);
    write_reg(bsc_pkg::CfgOffsetY, 32'h0);
    calibrate(12'd0, 12'd0);
    calibrate(12'd4095, 12'd4095);
    drain();
    // full mesh, samples far outside it
    set_shape(3, 3, 16, 16);
    write_reg(bsc_pkg::CfgScaleX, 32'h7fffffff);
    write_reg(bsc_pkg::CfgOffsetX, 32'h7fffffff);
    write_reg(bsc_pkg::CfgScaleY, 32'h80000000);
    write_reg(bsc_pkg::CfgOffsetY, 32'h80000000);
    calibrate(12'd4095, 12'd4095);
    calibrate(12'd0, 12'd0);
    calibrate(12'd1, 12'd2048);
    drain();
    // mixed degrees, oversize mesh registers
    set_shape(1, 2, 31, 31);
    fit_scales(16, 16);
    calibrate(12'd4095, 12'd0);
    calibrate(12'd0, 12'd4095);
    calibrate(12'd2048, 12'd1024);
    drain();
    set_shape(2, 1, 2, 3);
    write_reg(bsc_pkg::CfgOffsetX, 32'hfff00000);
    calibrate(12'd100, 12'd4000);
    calibrate(12'd4095, 12'd4095);
    drain();
  endtask

  task automatic test_random;
    int dx, dy, w, h;
    for (int phase = 0; phase < 12; phase++) begin
      dx = (phase < 2) ? 3 : $urandom_range(3);
      dy = (phase < 2) ? 3 : $urandom_range(3);
      w = (phase == 0) ? 16 : $urandom_range(17, dx + 1);
      h = (phase == 0) ? 16 : $urandom_range(17, dy + 1);
      if (w > 16) w = 16;
      if (h > 16) h = 16;
      set_shape(dx, dy, w, h);
      if (phase == 11) begin
        write_reg(bsc_pkg::CfgScaleX, $urandom);
        write_reg(bsc_pkg::CfgOffsetX, $urandom);
        write_reg(bsc_pkg::CfgScaleY, $urandom);
        write_reg(bsc_pkg::CfgOffsetY, $urandom);
      end else begin
        fit_scales(w, h);
      end
      steady = (phase == 4);
      for (int n = 0; n < 70; n++) begin
        if ($urandom_range(99) < 20)
          load_point($urandom_range(15), $urandom_range(15), mesh_value(), mesh_value());
        else
          calibrate(12'($urandom), 12'($urandom));
      end
      drain();
      steady = 1'b0;
    end
  endtask

  initial begin
    cal_regs[bsc_pkg::CfgScaleX] = 32'h01000000;
    cal_regs[bsc_pkg::CfgOffsetX] = 32'h0;
    cal_regs[bsc_pkg::CfgScaleY] = 32'h01000000;
    cal_regs[bsc_pkg::CfgOffsetY] = 32'h0;
    cal_regs[bsc_pkg::CfgDegX] = 32'd3;
    cal_regs[bsc_pkg::CfgDegY] = 32'd3;
    cal_regs[bsc_pkg::CfgWidth] = 32'd4;
    cal_regs[bsc_pkg::CfgHeight] = 32'd4;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_fill_mesh();
    test_reset_defaults();
    test_directed();
    test_random();
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hw/rtl/bsc_pkg.sv
hw/rtl/bspline_surface_calibrate.sv
tb/bspline_surface_calibrate_test.sv
